/* rtl/pmi_pkg.sv */
// Package with the shared types, codes and parameters of the point motion interpolator.
package pmi_pkg;

  localparam int NumPoints = 16;
  localparam int IdxW = 4;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_TWEEN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WRAP_W = 2'd0,
    CFG_WRAP_H = 2'd1,
    CFG_FILTER = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FM_DIRECT = 2'd0,
    FM_INTERP = 2'd1,
    FM_EXTRAP = 2'd2
  } fmode_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [8:0] fraction;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic moved;
  } out_req_t;

  typedef struct packed {
    op_t op;
    logic null_item;
    logic [IdxW-1:0] idx;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [8:0] frac;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MOD0,
    S_MOD0W,
    S_UNWRAP,
    S_MUL,
    S_SUM,
    S_MOD1,
    S_MOD1W,
    S_OUT
  } bstate_t;

endpackage

/* rtl/pmi_front.sv */
// Front part: accepts requests, classifies them and queues commands for the back part.
module pmi_front import pmi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  in_req_t in_data,
  input  logic    in_valid,
  output logic    in_ready,
  output cmd_t    cmd,
  output logic    cmd_valid,
  input  logic    cmd_take
);

  cmd_t q [QDepth];
  logic wp, rp;
  logic [1:0] cnt;
  cmd_t c;
  logic push, pop;

  always_comb begin
    c.op = op_t'(in_data.op);
    c.null_item = ({1'b0, in_data.point_index} >= 5'(NumPoints));
    c.idx = in_data.point_index[IdxW-1:0];
    c.pos_x = in_data.pos_x;
    c.pos_y = in_data.pos_y;
    c.vel_x = in_data.vel_x;
    c.vel_y = in_data.vel_y;
    c.acc_x = in_data.acc_x;
    c.acc_y = in_data.acc_y;
    c.frac = (in_data.fraction > 9'd256) ? 9'd256 : in_data.fraction;
  end

  assign in_ready = (cnt != 2'(QDepth));
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt != 2'd0);
  assign pop = cmd_take && cmd_valid;
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/pmi_emod.sv */
// Iterative Euclidean modulo of a signed 32-bit value by an unsigned 31-bit size; a zero size passes the value through.
module pmi_emod import pmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] v,
  input  logic [30:0] w,
  output logic        busy,
  output logic [31:0] r
);

  logic [31:0] mag;
  logic [31:0] rem;
  logic [30:0] wq;
  logic neg;
  logic [5:0] cnt;
  logic [32:0] trial;
  logic [31:0] rem_next;

  assign trial = {rem[31:0], mag[31]} - {2'b0, wq};
  assign rem_next = trial[32] ? {rem[30:0], mag[31]} : trial[31:0];

  always_comb begin
    if (wq == 31'd0) r = mag;
    else if (neg && rem != 32'd0) r = {1'b0, wq} - rem;
    else r = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 6'd0;
    end else if (start) begin
      wq <= w;
      neg <= v[31];
      rem <= 32'd0;
      if (w == 31'd0) begin
        mag <= v;
        busy <= 1'b0;
      end else begin
        mag <= v[31] ? (32'd0 - v) : v;
        busy <= 1'b1;
        cnt <= 6'd32;
      end
    end else if (busy) begin
      rem <= rem_next;
      mag <= {mag[30:0], 1'b0};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

endmodule

/* rtl/pmi_back.sv */
// Back part: point table, sequencer and arithmetic that carry out queued commands.
module pmi_back import pmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  logic [30:0] wrap_w,
  input  logic [30:0] wrap_h,
  input  logic [1:0]  fmode,
  output out_req_t    out_data,
  output logic        out_valid,
  input  logic        out_ready
);

  logic [31:0] t_cx [NumPoints];
  logic [31:0] t_cy [NumPoints];
  logic [31:0] t_vx [NumPoints];
  logic [31:0] t_vy [NumPoints];
  logic [31:0] t_ax [NumPoints];
  logic [31:0] t_ay [NumPoints];
  logic [31:0] t_px [NumPoints];
  logic [31:0] t_py [NumPoints];
  logic [31:0] t_sx [NumPoints];
  logic [31:0] t_sy [NumPoints];

  bstate_t state, state_next;
  cmd_t c;
  out_req_t res;
  logic [31:0] cx, cy, px, py, sx, sy, ox, oy;
  logic signed [41:0] prodx, prody;
  logic [31:0] nx, ny;
  logic mx_start, my_start, mx_busy, my_busy;
  logic [31:0] mx_in, my_in, mx_r, my_r;
  logic [30:0] whx, why;
  logic [31:0] upx, upy;
  logic interp;

  pmi_emod u_modx (.clk, .rst, .start(mx_start), .v(mx_in), .w(wrap_w),
    .busy(mx_busy), .r(mx_r));
  pmi_emod u_mody (.clk, .rst, .start(my_start), .v(my_in), .w(wrap_h),
    .busy(my_busy), .r(my_r));

  assign interp = (fmode == FM_INTERP) || (fmode == FM_EXTRAP);
  assign whx = {1'b0, wrap_w[30:1]};
  assign why = {1'b0, wrap_h[30:1]};

  function automatic logic [31:0] unwrap(input logic [31:0] p, input logic [31:0] cu,
                                         input logic [30:0] w, input logic [30:0] h);
    logic signed [31:0] a, b;
    a = p - cu;
    b = cu - p;
    if (w == 31'd0) return p;
    if (a > $signed({1'b0, h})) return p - {1'b0, w};
    if (b > $signed({1'b0, h})) return p + {1'b0, w};
    return p;
  endfunction

  assign upx = unwrap(px, cx, wrap_w, whx);
  assign upy = unwrap(py, cy, wrap_h, why);

  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    mx_start = 1'b0;
    my_start = 1'b0;
    mx_in = sx;
    my_in = sy;
    unique case (state)
      S_IDLE: if (cmd_valid) begin
        cmd_take = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (c.null_item || c.op == OP_LOAD || c.op == OP_NONE) state_next = S_OUT;
        else state_next = S_MOD0;
      end
      S_MOD0: begin
        mx_start = 1'b1;
        my_start = 1'b1;
        state_next = S_MOD0W;
      end
      S_MOD0W: if (!mx_busy && !my_busy) begin
        if (c.op == OP_ADVANCE || !interp) state_next = S_OUT;
        else state_next = S_UNWRAP;
      end
      S_UNWRAP: state_next = S_MUL;
      S_MUL: state_next = S_SUM;
      S_SUM: state_next = S_MOD1;
      S_MOD1: begin
        mx_in = nx;
        my_in = ny;
        mx_start = 1'b1;
        my_start = 1'b1;
        state_next = S_MOD1W;
      end
      S_MOD1W: if (!mx_busy && !my_busy) state_next = S_OUT;
      S_OUT: if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_OUT && !out_valid) begin
        out_valid <= 1'b1;
        out_data <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) c <= cmd;
    if (state == S_RD) begin
      cx <= t_cx[c.idx];
      cy <= t_cy[c.idx];
      px <= t_px[c.idx];
      py <= t_py[c.idx];
      sx <= t_sx[c.idx];
      sy <= t_sy[c.idx];
      res <= '{disp_x: t_sx[c.idx], disp_y: t_sy[c.idx], moved: 1'b0};
      if (c.null_item) res <= '0;
      else if (c.op == OP_LOAD) begin
        t_cx[c.idx] <= c.pos_x;
        t_cy[c.idx] <= c.pos_y;
        t_vx[c.idx] <= c.vel_x;
        t_vy[c.idx] <= c.vel_y;
        t_ax[c.idx] <= c.acc_x;
        t_ay[c.idx] <= c.acc_y;
      end else if (c.op == OP_ADVANCE) begin
        t_px[c.idx] <= t_cx[c.idx];
        t_py[c.idx] <= t_cy[c.idx];
        t_cx[c.idx] <= t_cx[c.idx] + t_vx[c.idx];
        t_cy[c.idx] <= t_cy[c.idx] + t_vy[c.idx];
        t_vx[c.idx] <= t_vx[c.idx] + t_ax[c.idx];
        t_vy[c.idx] <= t_vy[c.idx] + t_ay[c.idx];
      end
    end
    if (state == S_MOD0W && !mx_busy && !my_busy) begin
      ox <= mx_r;
      oy <= my_r;
      if (c.op == OP_ADVANCE) begin
        t_sx[c.idx] <= mx_r;
        t_sy[c.idx] <= my_r;
        res <= '{disp_x: mx_r, disp_y: my_r, moved: 1'b0};
      end else if (!interp) begin
        t_sx[c.idx] <= cx;
        t_sy[c.idx] <= cy;
        res <= '{disp_x: cx, disp_y: cy,
                 moved: ((mx_r ^ cx) | (my_r ^ cy)) != 32'd0};
      end
    end
    if (state == S_UNWRAP) begin
      px <= upx;
      py <= upy;
      t_px[c.idx] <= upx;
      t_py[c.idx] <= upy;
    end
    if (state == S_MUL) begin
      prodx <= $signed(cx - px) * $signed({1'b0, c.frac});
      prody <= $signed(cy - py) * $signed({1'b0, c.frac});
    end
    if (state == S_SUM) begin
      nx <= ((fmode == FM_EXTRAP) ? cx : px) + prodx[39:8];
      ny <= ((fmode == FM_EXTRAP) ? cy : py) + prody[39:8];
    end
    if (state == S_MOD1W && !mx_busy && !my_busy) begin
      t_sx[c.idx] <= mx_r;
      t_sy[c.idx] <= my_r;
      res <= '{disp_x: mx_r, disp_y: my_r,
               moved: ((ox ^ mx_r) | (oy ^ my_r)) != 32'd0};
    end
    if (rst) begin
      for (int i = 0; i < NumPoints; i++) begin
        t_cx[i] <= '0; t_cy[i] <= '0; t_vx[i] <= '0; t_vy[i] <= '0;
        t_ax[i] <= '0; t_ay[i] <= '0; t_px[i] <= '0; t_py[i] <= '0;
        t_sx[i] <= '0; t_sy[i] <= '0;
      end
    end
  end

endmodule

/* rtl/point_motion_interpolator_core.sv */
// Top level of the point motion interpolator: configuration registers, front and back parts.
// Requests enter on in_data/in_valid/in_ready and each gives one result request on
// out_data/out_valid/out_ready. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, and the block itself does not
// enforce this. Indexes beyond the register list are ignored. A front part classifies each
// request into a two-entry queue; the back part works on one request at a time. Loads,
// out-of-range indexes and unused ops go from S_RD straight to S_OUT, which raises
// out_valid, and the back part takes the next request once it is back in S_IDLE.
// Advances and direct-copy tweens wait in S_MOD0W on the 32-step bit-serial Euclidean
// modulo that runs once for x and y in parallel. Interpolating and extrapolating tweens
// run it twice, waiting again in S_MOD1W.
// Synchronous reset clears the point table, the queue, the registers and out_valid.
// When the receiver stalls the result holds in the output register; the back part
// finishes one more request and holds it, and the queue takes up to two more requests
// before in_ready falls.
module point_motion_interpolator_core import pmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_req_t     in_data,
  input  logic        in_valid,
  output logic        in_ready,
  output out_req_t    out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic [30:0] wrap_w, wrap_h;
  logic [1:0] fmode;
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_w <= '0;
      wrap_h <= '0;
      fmode <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRAP_W: wrap_w <= cfg_data;
        CFG_WRAP_H: wrap_h <= cfg_data;
        CFG_FILTER: fmode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  pmi_front u_front (.clk, .rst, .in_data, .in_valid, .in_ready, .cmd, .cmd_valid,
    .cmd_take);

  pmi_back u_back (.clk, .rst, .cmd, .cmd_valid, .cmd_take, .wrap_w, .wrap_h, .fmode,
    .out_data, .out_valid, .out_ready);

endmodule
